FILE: hw/rtl/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_KEY_BITS    = 32;

	// Field widths fixed by the interface.
	localparam int VAL_W  = 32;
	localparam int KEY_W  = 32;
	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Register map, as word indexes (byte address / 4).
	localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

	// Capacity register reset value.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Result of a get that misses.
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// Action codes.
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} lkvc_state_t;

	// Update command broadcast from the sequencer to every cell.
	typedef struct packed {
		logic update;   // apply the command this cycle
		logic hit;      // the key was found; the matching cell is the target
		logic fill;     // a free cell is available; cell number "used" is the target
		logic age_all;  // every valid cell ages by one
		logic is_put;   // target takes the new key and value
	} lkvc_ctl_t;

endpackage

FILE: hw/rtl/lru_key_value_cache_top.sv
// A get's result strobes on done for one cycle, registered after the APPLY state.
// The block takes a new word only when idle; the lookup ripples through the
// row of cells, one cell per cycle, and the update is then broadcast to every cell in APPLY.
// Reset (arst_n, asynchronous): the cache empties and the capacity register returns to 16.
// The result receiver cannot stall; a put produces no result word.
`timescale 1ns / 1ps

module lru_key_value_cache_top #(
	parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_BITS    = lkvc_pkg::DEF_KEY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [lkvc_pkg::KEY_W-1:0]  key,
	input  logic [lkvc_pkg::VAL_W-1:0]  value,
	output logic                        done,
	output logic                        hit,
	output logic [lkvc_pkg::VAL_W-1:0]  read_value,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
	input  logic [lkvc_pkg::DATA_W-1:0] pwdata,
	output logic [lkvc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import lkvc_pkg::*;

	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int USED_W = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W  = RANK_W;
	localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int CMP_W  = ((USED_W > CAP_W) ? USED_W : CAP_W) + 1;

	lkvc_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [USED_W-1:0] used_q;
	logic [CAP_W-1:0]  capacity_q;
	logic              action_q;
	logic [KW-1:0]     key_q;
	logic [VAL_W-1:0]  value_q;
	logic              done_q;
	logic              hit_q;
	logic [VAL_W-1:0]  read_value_q;

	logic              accept;
	logic              cfg_wr;
	logic              reg_sel;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  limit;
	logic              fill;
	logic [RANK_W-1:0] lru_rank;
	logic [RANK_W-1:0] old_rank;
	lkvc_ctl_t         ctl;

	logic              chain_hit  [0:MAX_ENTRIES];
	logic [VAL_W-1:0]  chain_val  [0:MAX_ENTRIES];
	logic [RANK_W-1:0] chain_rank [0:MAX_ENTRIES];

	assign accept = start && !busy;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_CAPACITY);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Effective capacity: zero counts as one, large values saturate.
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			limit = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			limit = CMP_W'(MAX_ENTRIES);
		end else begin
			limit = cap_ext;
		end
		fill     = CMP_W'(used_q) < limit;
		lru_rank = RANK_W'(used_q - USED_W'(1));
	end

	// Request word capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			key_q    <= key[KW-1:0];
			value_q  <= value;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the update command to the cells.
	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		ctl.update  = 1'b0;
		ctl.hit     = chain_hit[MAX_ENTRIES];
		ctl.fill    = fill;
		ctl.age_all = !chain_hit[MAX_ENTRIES] && fill;
		ctl.is_put  = (action_q == ACT_PUT);
		old_rank    = chain_hit[MAX_ENTRIES] ? chain_rank[MAX_ENTRIES] : lru_rank;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(MAX_ENTRIES - 1)) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				ctl.update = chain_hit[MAX_ENTRIES] || (action_q == ACT_PUT);
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Scan counter, fill count and result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_APPLY) && (action_q == ACT_GET);
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.update && ctl.is_put && !ctl.hit && fill) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			hit_q        <= chain_hit[MAX_ENTRIES];
			read_value_q <= chain_hit[MAX_ENTRIES] ? chain_val[MAX_ENTRIES] : MISS_VALUE;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// Row of cells; the lookup chain starts empty.
	assign chain_hit[0]  = 1'b0;
	assign chain_val[0]  = '0;
	assign chain_rank[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.MAX_ENTRIES (MAX_ENTRIES),
			.KW          (KW),
			.IDX         (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.key_in         (key_q),
			.value_in       (value_q),
			.used           (used_q),
			.lru_rank       (lru_rank),
			.old_rank       (old_rank),
			.chain_hit_in   (chain_hit[i]),
			.chain_val_in   (chain_val[i]),
			.chain_rank_in  (chain_rank[i]),
			.chain_hit_out  (chain_hit[i+1]),
			.chain_val_out  (chain_val[i+1]),
			.chain_rank_out (chain_rank[i+1])
		);
	end

endmodule

FILE: hw/rtl/lkvc_cell.sv
`timescale 1ns / 1ps

module lkvc_cell #(
	parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
	parameter int KW          = lkvc_pkg::KEY_W,
	parameter int IDX         = 0,
	localparam int RANK_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int USED_W     = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lkvc_pkg::lkvc_ctl_t       ctl,
	input  logic [KW-1:0]             key_in,
	input  logic [lkvc_pkg::VAL_W-1:0] value_in,
	input  logic [USED_W-1:0]         used,
	input  logic [RANK_W-1:0]         lru_rank,
	input  logic [RANK_W-1:0]         old_rank,
	input  logic                      chain_hit_in,
	input  logic [lkvc_pkg::VAL_W-1:0] chain_val_in,
	input  logic [RANK_W-1:0]         chain_rank_in,
	output logic                      chain_hit_out,
	output logic [lkvc_pkg::VAL_W-1:0] chain_val_out,
	output logic [RANK_W-1:0]         chain_rank_out
);
	import lkvc_pkg::*;

	logic              valid_q;
	logic [KW-1:0]     key_q;
	logic [VAL_W-1:0]  val_q;
	logic [RANK_W-1:0] rank_q;
	logic              chain_hit_q;
	logic [VAL_W-1:0]  chain_val_q;
	logic [RANK_W-1:0] chain_rank_q;
	logic              match;
	logic              is_lru;
	logic              target;

	// Local compare and role of this cell in the current command.
	always_comb begin
		match  = valid_q && (key_q == key_in);
		is_lru = valid_q && (rank_q == lru_rank);
		if (ctl.hit) begin
			target = match;
		end else if (ctl.fill) begin
			target = (used == USED_W'(IDX));
		end else begin
			target = is_lru;
		end
	end

	// Lookup chain: the hit, value and rank of the matching cell ripple toward the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_hit_q <= 1'b0;
		end else begin
			chain_hit_q <= chain_hit_in | match;
		end
	end

	always_ff @(posedge clk) begin
		chain_val_q  <= chain_val_in | (match ? val_q : '0);
		chain_rank_q <= chain_rank_in | (match ? rank_q : '0);
	end

	assign chain_hit_out  = chain_hit_q;
	assign chain_val_out  = chain_val_q;
	assign chain_rank_out = chain_rank_q;

	// Valid bit and recency rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctl.update) begin
			if (target) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (ctl.age_all || (rank_q < old_rank))) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	// Stored key and value, written only when this cell takes a put.
	always_ff @(posedge clk) begin
		if (ctl.update && target && ctl.is_put) begin
			key_q <= key_in;
			val_q <= value_in;
		end
	end

endmodule

FILE: hw/rtl/lkvc_checker.sv
`timescale 1ns / 1ps

module lkvc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        hit,
	input logic [lkvc_pkg::VAL_W-1:0]  read_value,
	input logic                        pready
);
	import lkvc_pkg::*;

	// An accepted request word keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting a word");

	// A result word appears only once the block has finished its work.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// A result word is a single-cycle strobe.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A miss returns all ones.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> read_value == MISS_VALUE)
		else $error("miss returned a value other than all ones");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);
